// ===== rtl/dncs_pkg.sv =====
// Shared types, constants and register codes of the day/night duty-cycle scheduler.
// No dependencies; every other file except the checker imports this package.
package dncs_pkg;

  localparam int unsigned TimeW    = 11;  // minute-of-day and register width
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivSteps = TimeW;  // one remainder bit per stage

  localparam logic [TimeW-1:0] MinPerHour = 11'd60;
  localparam logic [SecW-1:0]  SecPerMin  = 6'd60;
  localparam logic [TimeW:0]   MinPerDay  = 12'd1440;
  localparam logic [TimeW:0]   TwoDays    = 12'd2880;
  // hour = (minute * 1093) >> 16 is exact for minute < 1440
  localparam logic [21:0]      Recip60    = 22'd1093;
  localparam int unsigned      RecipShift = 16;

  localparam logic [TimeW-1:0] DayStartRst   = 11'd480;
  localparam logic [TimeW-1:0] NightStartRst = 11'd1320;
  localparam logic [TimeW-1:0] DayCycRst     = 11'd60;
  localparam logic [TimeW-1:0] DayOnRst      = 11'd30;
  localparam logic [TimeW-1:0] NightCycRst   = 11'd60;
  localparam logic [TimeW-1:0] NightOnRst    = 11'd15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DAY_START   = 3'd0,
    REG_NIGHT_START = 3'd1,
    REG_DAY_CYC     = 3'd2,
    REG_DAY_ON      = 3'd3,
    REG_NIGHT_CYC   = 3'd4,
    REG_NIGHT_ON    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [TimeW-1:0] day_start;
    logic [TimeW-1:0] night_start;
    logic [TimeW-1:0] day_cyc;
    logic [TimeW-1:0] day_on;
    logic [TimeW-1:0] night_cyc;
    logic [TimeW-1:0] night_on;
  } dncs_cfg_t;

  // Item state while the cycle remainder is being worked out
  typedef struct packed {
    logic [TimeW-1:0] om;   // minutes since period start, seconds carry folded in
    logic [TimeW-1:0] rem;  // partial remainder of om by cyc
    logic [TimeW-1:0] cyc;  // cycle length, zero clamped to one
    logic [TimeW-1:0] on;
    logic [TimeW-1:0] mc;   // minute of day, seconds carry folded in
    logic             day;
  } dncs_work_t;

  typedef struct packed {
    logic             drive;
    logic             day;
    logic [TimeW-1:0] cyc;
    logic [TimeW-1:0] on;
    logic [TimeW-1:0] mtc;  // minutes to next change
  } dncs_res_t;

endpackage

// ===== rtl/dncs_cfg.sv =====
// Configuration register file of the scheduler.
// Depends on dncs_pkg.
module dncs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dncs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dncs_pkg::TimeW-1:0]     cfg_data,
  output dncs_pkg::dncs_cfg_t            cfg_o
);
  import dncs_pkg::*;

  dncs_cfg_t regs_r, regs_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DAY_START:   regs_nxt.day_start   = cfg_data;
        REG_NIGHT_START: regs_nxt.night_start = cfg_data;
        REG_DAY_CYC:     regs_nxt.day_cyc     = cfg_data;
        REG_DAY_ON:      regs_nxt.day_on      = cfg_data;
        REG_NIGHT_CYC:   regs_nxt.night_cyc   = cfg_data;
        REG_NIGHT_ON:    regs_nxt.night_on    = cfg_data;
        default:         regs_nxt = regs_r;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{day_start: DayStartRst, night_start: NightStartRst,
                  day_cyc: DayCycRst, day_on: DayOnRst,
                  night_cyc: NightCycRst, night_on: NightOnRst};
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== rtl/dncs_front.sv =====
// Entry stage: minute of day, profile choice and offset into the period.
// Depends on dncs_pkg.
module dncs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dncs_pkg::dncs_cfg_t         cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dncs_pkg::HourW-1:0]  hour_now,
  input  logic [dncs_pkg::MinW-1:0]   minute_now,
  input  logic [dncs_pkg::SecW-1:0]   second_now,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dncs_pkg::dncs_work_t        out_work
);
  import dncs_pkg::*;

  logic             valid_r, valid_nxt;
  dncs_work_t       work_r, work_nxt;
  logic [TimeW-1:0] m, off_min, cyc_sel, on_sel;
  logic [TimeW:0]   m_wrap;
  logic             carry, day;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_work  = work_r;

  always_comb begin
    m      = TimeW'(hour_now) * MinPerHour + TimeW'(minute_now);
    m_wrap = {1'b0, m} + MinPerDay;
    carry  = (second_now >= SecPerMin);  // 60..63 s roll into the next minute
    day    = (m >= cfg.day_start) && (m < cfg.night_start);
    if (day) begin
      cyc_sel = cfg.day_cyc;
      on_sel  = cfg.day_on;
      off_min = m - cfg.day_start;
    end else begin
      cyc_sel = cfg.night_cyc;
      on_sel  = cfg.night_on;
      if (m >= cfg.night_start) begin
        off_min = m - cfg.night_start;
      end else if (m_wrap >= {1'b0, cfg.night_start}) begin
        off_min = TimeW'(m_wrap - {1'b0, cfg.night_start});
      end else begin
        off_min = '0;
      end
    end
    work_nxt.om  = off_min + TimeW'(carry);
    work_nxt.rem = '0;
    work_nxt.cyc = (cyc_sel == '0) ? TimeW'(1) : cyc_sel;
    work_nxt.on  = on_sel;
    work_nxt.mc  = m + TimeW'(carry);
    work_nxt.day = day;
    valid_nxt    = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      work_r <= work_nxt;
    end
  end

endmodule

// ===== rtl/dncs_rem_stage.sv =====
// One restoring-remainder step: brings in one bit of the offset, subtracts the cycle.
// Depends on dncs_pkg.
module dncs_rem_stage #(
  parameter int unsigned BitIdx = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dncs_pkg::dncs_work_t in_work,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dncs_pkg::dncs_work_t out_work
);
  import dncs_pkg::*;

  logic           valid_r, valid_nxt;
  dncs_work_t     work_r, work_nxt;
  logic [TimeW:0] rem_sh;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_work  = work_r;

  always_comb begin
    rem_sh   = {in_work.rem, in_work.om[BitIdx]};
    work_nxt = in_work;
    if (rem_sh >= {1'b0, in_work.cyc}) begin
      work_nxt.rem = TimeW'(rem_sh - {1'b0, in_work.cyc});
    end else begin
      work_nxt.rem = TimeW'(rem_sh);
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      work_r <= work_nxt;
    end
  end

endmodule

// ===== rtl/dncs_back.sv =====
// Back end: on/off decision, time to change, day wrap, hour/minute split, output register.
// Depends on dncs_pkg.
module dncs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dncs_pkg::dncs_work_t        in_work,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dncs_pkg::dncs_res_t         out_res,
  output logic [dncs_pkg::HourW-1:0]  out_hour,
  output logic [dncs_pkg::MinW-1:0]   out_minute
);
  import dncs_pkg::*;

  // valid bits of the four stages
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  dncs_res_t        res1_r, res2_r, res3_r, res4_r, res1_nxt;
  logic [TimeW:0]   t1_r, t1_nxt;              // change minute, not yet wrapped
  logic [TimeW-1:0] nm2_r, nm2_nxt, nm3_r;      // change minute of day
  logic [HourW-1:0] hr3_r, hr3_nxt, hr4_r;
  logic [MinW-1:0]  mn4_r, mn4_nxt;
  logic [21:0]      prod;
  logic [TimeW-1:0] hr_min;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid  = v4_r;
  assign out_res    = res4_r;
  assign out_hour   = hr4_r;
  assign out_minute = mn4_r;

  always_comb begin
    // stage 1: phase below on time, minutes to the next edge
    res1_nxt.drive = (in_work.rem < in_work.on);
    res1_nxt.day   = in_work.day;
    res1_nxt.cyc   = in_work.cyc;
    res1_nxt.on    = in_work.on;
    res1_nxt.mtc   = res1_nxt.drive ? (in_work.on - in_work.rem)
                                    : (in_work.cyc - in_work.rem);
    t1_nxt         = {1'b0, in_work.mc} + {1'b0, res1_nxt.mtc};
    // stage 2: wrap into one day (t stays below three days)
    if (t1_r >= TwoDays) begin
      nm2_nxt = TimeW'(t1_r - TwoDays);
    end else if (t1_r >= MinPerDay) begin
      nm2_nxt = TimeW'(t1_r - MinPerDay);
    end else begin
      nm2_nxt = TimeW'(t1_r);
    end
    // stage 3: hour by reciprocal
    prod    = 22'(nm2_r) * Recip60;
    hr3_nxt = prod[RecipShift +: HourW];
    // stage 4: minute of hour
    hr_min  = TimeW'(hr3_r) * MinPerHour;
    mn4_nxt = MinW'(nm3_r - hr_min);

    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      res1_r <= res1_nxt;
      t1_r   <= t1_nxt;
    end
    if (v1_r && rdy2) begin
      res2_r <= res1_r;
      nm2_r  <= nm2_nxt;
    end
    if (v2_r && rdy3) begin
      res3_r <= res2_r;
      nm3_r  <= nm2_r;
      hr3_r  <= hr3_nxt;
    end
    if (v3_r && rdy4) begin
      res4_r <= res3_r;
      hr4_r  <= hr3_r;
      mn4_r  <= mn4_nxt;
    end
  end

endmodule

// ===== rtl/day_night_duty_cycle_schedule.sv =====
// Top level of the day/night duty-cycle scheduler.
// Depends on dncs_pkg, dncs_cfg, dncs_front, dncs_rem_stage and dncs_back.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | time of day: hour, minute, second
//  out_    | out | out_tvalid/out_tready| drive state, profile lengths, next change
//  cfg_    | in  | cfg_valid/cfg_ready  | register index and 11-bit value, always taken
//
// Throughput: one beat per clock while out_tready stays high; the path from input to
//   output beat is the entry stage, 11 remainder stages of one bit each, 4 back-end stages.
// The depth is set by the bit-serial remainder of the period offset by the cycle.
// Reset: synchronous on rst_n low; clears every stage valid bit and loads the
//   register defaults. Stalls: each stage holds while its successor is full, so
//   bubbles close up and a beat is neither dropped nor repeated.
module day_night_duty_cycle_schedule (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hour_now[4:0], minute_now[10:5], second_now[16:11], 0
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // drive_on[0], active_cycle_len[11:1],
                                  // active_on_len[22:12], minutes_to_change[33:23],
                                  // change_hour[38:34], change_minute[44:39], 0
  output logic        out_tuser,  // in_day
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import dncs_pkg::*;

  dncs_cfg_t        cfg;
  logic             front_valid, front_ready;
  dncs_work_t       front_work;

  // div_*[0] is the entry stage output, div_*[DivSteps] feeds the back end
  logic [DivSteps:0] div_valid, div_ready;
  dncs_work_t        div_work [DivSteps+1];

  dncs_res_t        res;
  logic [HourW-1:0] chg_hour;
  logic [MinW-1:0]  chg_minute;

  dncs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  dncs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .hour_now   (in_tdata[4:0]),
    .minute_now (in_tdata[10:5]),
    .second_now (in_tdata[16:11]),
    .out_valid  (front_valid),
    .out_ready  (front_ready),
    .out_work   (front_work)
  );

  assign div_valid[0] = front_valid;
  assign div_work[0]  = front_work;
  assign front_ready  = div_ready[0];

  // remainder chain, most significant offset bit first
  for (genvar k = 0; k < DivSteps; k++) begin : g_rem
    dncs_rem_stage #(
      .BitIdx (DivSteps - 1 - k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[k]),
      .in_ready  (div_ready[k]),
      .in_work   (div_work[k]),
      .out_valid (div_valid[k+1]),
      .out_ready (div_ready[k+1]),
      .out_work  (div_work[k+1])
    );
  end

  dncs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (div_valid[DivSteps]),
    .in_ready   (div_ready[DivSteps]),
    .in_work    (div_work[DivSteps]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res),
    .out_hour   (chg_hour),
    .out_minute (chg_minute)
  );

  assign out_tdata = {3'b000, chg_minute, chg_hour, res.mtc, res.on, res.cyc, res.drive};
  assign out_tuser = res.day;

endmodule

// ===== rtl/dncs_chk.sv =====
// Port-level checker for the scheduler, bound to the top level.
// Depends on the top level's port list only.
module dncs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  logic        drive;
  logic [10:0] cyc, on, mtc;
  logic [4:0]  chg_hour;
  logic [5:0]  chg_minute;

  assign drive      = out_tdata[0];
  assign cyc        = out_tdata[11:1];
  assign on         = out_tdata[22:12];
  assign mtc        = out_tdata[33:23];
  assign chg_hour   = out_tdata[38:34];
  assign chg_minute = out_tdata[44:39];

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chg_hour < 5'd24 && chg_minute < 6'd60 && cyc != 11'd0)
    else $error("change time not wrapped or zero cycle length");

  // the next edge lies within the on time or the rest of the cycle
  a_until: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> mtc != 11'd0 && (drive ? (mtc <= on) : (mtc <= cyc)))
    else $error("minutes to change out of range");

endmodule

bind day_night_duty_cycle_schedule dncs_chk u_dncs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
